// File: design/aac_pkg.sv
// Shared types and constants for the row-major array address calculator.
// Used by every module of the block but aac_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package aac_pkg;

  // Descriptor table geometry
  localparam int NUM_ARRAYS  = 16;
  localparam int MAX_DIMS    = 10;
  localparam int SLOT_DEPTH  = NUM_ARRAYS * MAX_DIMS;
  localparam int SLOT_W      = $clog2(SLOT_DEPTH);
  localparam int ARR_W       = $clog2(NUM_ARRAYS);

  // Fixed field widths
  localparam int ID_W        = 4;
  localparam int WORD_W      = 32;
  localparam int IN_DATA_W   = 160;
  localparam int OUT_DATA_W  = 40;
  localparam int OP_W        = 2;

  // Front-to-back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Item kinds, as carried in tuser
  localparam logic [OP_W-1:0] OP_HEADER = 2'd0;
  localparam logic [OP_W-1:0] OP_BOUND  = 2'd1;
  localparam logic [OP_W-1:0] OP_INDEX  = 2'd2;

  // One classified item on its way to the back end
  typedef struct packed {
    logic [OP_W-1:0]   kind;
    logic [ID_W-1:0]   id;
    logic [SLOT_W-1:0] slot;
    logic              last;
    logic [WORD_W-1:0] opa;   // base, lower bound or index value
    logic [WORD_W-1:0] opb;   // element size or upper bound
  } aac_item_t;

endpackage
`default_nettype wire

// File: design/aac_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none
module aac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/aac_front.sv
// Front end: unpacks the input stream, drops items that name no valid
// descriptor or dimension, and pushes the rest into the queue. Uses aac_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aac_front (
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [aac_pkg::IN_DATA_W-1:0] s_tdata,
  input  wire logic [aac_pkg::OP_W-1:0]      s_tuser,
  input  wire logic                          s_tlast,
  input  wire logic                          q_full,
  output logic                               q_push,
  output aac_pkg::aac_item_t                 q_item
);
  import aac_pkg::*;

  logic [ID_W-1:0]   array_id;
  logic [WORD_W-1:0] base_addr;
  logic [15:0]       element_size;
  logic [3:0]        dim_number;
  logic [WORD_W-1:0] lower_bound;
  logic [WORD_W-1:0] upper_bound;
  logic [WORD_W-1:0] index_value;
  logic              id_ok;
  logic              dim_ok;
  logic              keep;

  // Unpack tdata; dim count (bits 55:52) takes no part in any address
  assign array_id     = s_tdata[3:0];
  assign base_addr    = s_tdata[35:4];
  assign element_size = s_tdata[51:36];
  assign dim_number   = s_tdata[59:56];
  assign lower_bound  = s_tdata[91:60];
  assign upper_bound  = s_tdata[123:92];
  assign index_value  = s_tdata[155:124];

  // Classify: drop unknown kinds and out-of-range ids or dimensions
  assign id_ok  = int'(array_id) < NUM_ARRAYS;
  assign dim_ok = (dim_number != 4'd0) && (int'(dim_number) <= MAX_DIMS);

  always_comb begin
    keep = 1'b0;
    unique case (s_tuser)
      OP_HEADER: keep = id_ok;
      OP_BOUND:  keep = id_ok && dim_ok;
      OP_INDEX:  keep = id_ok && dim_ok;
      default:   keep = 1'b0;
    endcase
  end

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full && keep;

  // Build the queue entry; the stride slot is id * MAX_DIMS + dim - 1
  always_comb begin
    q_item.kind = s_tuser;
    q_item.id   = array_id;
    q_item.slot = SLOT_W'(array_id) * SLOT_W'(MAX_DIMS) + SLOT_W'(dim_number)
                  - SLOT_W'(1);
    q_item.last = s_tlast;
    q_item.opa  = index_value;
    q_item.opb  = '0;
    unique case (s_tuser)
      OP_HEADER: begin
        q_item.opa = base_addr;
        q_item.opb = WORD_W'(element_size);
      end
      OP_BOUND: begin
        q_item.opa = lower_bound;
        q_item.opb = upper_bound;
      end
      default: begin
        q_item.opa = index_value;
        q_item.opb = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: design/aac_queue.sv
// Short FIFO of classified items between the front and back ends.
// Uses aac_pkg for the item type and depth.
`timescale 1ns / 1ps
`default_nettype none
module aac_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire aac_pkg::aac_item_t push_item,
  output logic                    full,
  input  wire logic               pop,
  output logic                    not_empty,
  output aac_pkg::aac_item_t      head
);
  import aac_pkg::*;

  aac_item_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full      = count == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: design/aac_back.sv
// Back end: sequencer that applies headers, bounds and index items to the
// descriptor tables with one shared multiplier. Uses aac_pkg and aac_ram.
`timescale 1ns / 1ps
`default_nettype none
module aac_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           q_not_empty,
  input  wire aac_pkg::aac_item_t             q_head,
  output logic                                q_pop,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic      [aac_pkg::OUT_DATA_W-1:0] m_tdata
);
  import aac_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_BOUND2  = 3'd1;
  localparam logic [2:0] ST_IDX_MUL = 3'd2;
  localparam logic [2:0] ST_IDX_ACC = 3'd3;
  localparam logic [2:0] ST_OUT     = 3'd4;

  logic [2:0]        state;
  logic [2:0]        state_next;
  aac_item_t         cur;
  logic [WORD_W-1:0] running_stride;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] extent;
  logic [WORD_W-1:0] offset_tab [NUM_ARRAYS];
  logic [WORD_W-1:0] mul_a;
  logic [WORD_W-1:0] mul_b;
  logic [WORD_W-1:0] mul_p;
  logic [WORD_W-1:0] acc_sum;
  logic              ram_we;
  logic [WORD_W-1:0] stride_rd;
  logic              out_free;
  logic [ID_W-1:0]   out_id;
  logic [WORD_W-1:0] out_addr;

  assign out_free = !m_tvalid || m_tready;
  assign acc_sum  = acc + prod;
  assign m_tdata  = {(OUT_DATA_W - ID_W - WORD_W)'(0), out_addr, out_id};

  // Per-dimension strides
  assign ram_we = (state == ST_IDLE) && q_not_empty && (q_head.kind == OP_BOUND);

  aac_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOT_DEPTH)
  ) u_stride_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_head.slot),
    .wdata (running_stride),
    .raddr (q_head.slot),
    .rdata (stride_rd)
  );

  // Shared multiplier operand select
  always_comb begin
    mul_a = running_stride;
    mul_b = q_head.opa;
    unique case (state)
      ST_BOUND2: begin
        mul_a = running_stride;
        mul_b = extent;
      end
      ST_IDX_MUL: begin
        mul_a = stride_rd;
        mul_b = cur.opa;
      end
      default: begin
        mul_a = running_stride;
        mul_b = q_head.opa;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Sequencer transitions
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_not_empty) begin
          q_pop = 1'b1;
          if (q_head.kind == OP_BOUND) begin
            state_next = ST_BOUND2;
          end else if (q_head.kind == OP_INDEX) begin
            state_next = ST_IDX_MUL;
          end
        end
      end
      ST_BOUND2:  state_next = ST_IDLE;
      ST_IDX_MUL: state_next = ST_IDX_ACC;
      ST_IDX_ACC: state_next = cur.last ? ST_OUT : ST_IDLE;
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state, running stride and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      running_stride <= '0;
      acc            <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && q_not_empty && q_head.kind == OP_HEADER) begin
        running_stride <= q_head.opb;
      end else if (state == ST_BOUND2) begin
        running_stride <= mul_p;
      end
      if (state == ST_IDX_ACC) begin
        acc <= acc_sum;
      end else if (state == ST_OUT && out_free) begin
        acc <= '0;
      end
      if (state == ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload: current item, products, offsets and the result register
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_not_empty) begin
      cur <= q_head;
      if (q_head.kind == OP_HEADER) begin
        offset_tab[q_head.id[ARR_W-1:0]] <= q_head.opa;
      end
      if (q_head.kind == OP_BOUND) begin
        prod   <= mul_p;
        extent <= q_head.opb - q_head.opa + WORD_W'(1);
      end
    end
    if (state == ST_BOUND2) begin
      offset_tab[cur.id[ARR_W-1:0]] <= offset_tab[cur.id[ARR_W-1:0]] - prod;
    end
    if (state == ST_IDX_MUL) begin
      prod <= mul_p;
    end
    if (state == ST_OUT && out_free) begin
      out_id   <= cur.id;
      out_addr <= offset_tab[cur.id[ARR_W-1:0]] + acc;
    end
  end

endmodule
`default_nettype wire

// File: design/multidim_array_address_calc_top.sv
// Top level of the row-major array address calculator: front end, item
// queue and back-end sequencer. Uses aac_pkg, aac_front, aac_queue, aac_back.
//
//  Channel | Direction | Payload
//  s_*     | in        | tuser = op, tlast = last_index, tdata = item fields
//  m_*     | out       | tdata = result_array, physical_address
//
// The front end takes one transfer per cycle, while the queue is not full, into a 4-entry queue.
// The back end takes a header in ST_IDLE, a bound via ST_BOUND2, an index
// item via ST_IDX_MUL and ST_IDX_ACC, and one that ends a query via ST_OUT
// too; the shared 32x32 multiplier and the registered stride RAM read set these steps.
// Reset clears the queue, the sequencer, the running stride and the sum.
// A stalled result holds in the output register; the queue keeps filling.
`timescale 1ns / 1ps
`default_nettype none
module multidim_array_address_calc_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // array_id[3:0], base_addr[35:4], element_size[51:36], dim_count[55:52],
  // dim_number[59:56], lower_bound[91:60], upper_bound[123:92],
  // index_value[155:124], zero fill[159:156]
  input  wire logic [aac_pkg::IN_DATA_W-1:0]  s_tdata,
  // op[1:0]
  input  wire logic [aac_pkg::OP_W-1:0]       s_tuser,
  input  wire logic                           s_tlast,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // result_array[3:0], physical_address[35:4], zero fill[39:36]
  output logic      [aac_pkg::OUT_DATA_W-1:0] m_tdata
);
  import aac_pkg::*;

  aac_item_t push_item;
  aac_item_t head;
  logic      push;
  logic      full;
  logic      pop;
  logic      not_empty;

  aac_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_full   (full),
    .q_push   (push),
    .q_item   (push_item)
  );

  aac_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  aac_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (not_empty),
    .q_head      (head),
    .q_pop       (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule
`default_nettype wire
